// ===== rtl/owbm_pkg.sv =====
// ----------------------------------------------------------------------------
// owbm_pkg
// shared types, codes and timing constants of the one-wire bus master
// ----------------------------------------------------------------------------
package owbm_pkg;

  // command codes carried with each tick
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } opcode_e;

  // pin drive codes
  localparam logic [1:0] MODE_LOW  = 2'd0;
  localparam logic [1:0] MODE_HIGH = 2'd1;
  localparam logic [1:0] MODE_REL  = 2'd2;

  // span lengths in microseconds
  localparam logic [8:0] T_RST_LOW  = 9'd500;
  localparam logic [8:0] T_RST_HIGH = 9'd80;
  localparam logic [8:0] T_W1_HIGH  = 9'd65;
  localparam logic [8:0] T_W0_LOW   = 9'd70;
  localparam logic [8:0] T_R_WAIT   = 9'd45;
  localparam logic [8:0] T_REC      = 9'd5;
  localparam logic [8:0] T_W1_LOW   = 9'd5;
  localparam logic [8:0] T_R_SHORT  = 9'd2;

  localparam logic [7:0] CPM_RESET = 8'd1;

  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] data_byte;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0] line_mode;
    logic       busy_res;
    logic       done_res;
    logic       no_presence;
    logic [7:0] read_data;
    logic       rejected;
  } result_t;

endpackage

// ===== rtl/one_wire_bus_master_unit.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit
// one-wire bus master: reset/presence, byte write and byte read sequences
// ----------------------------------------------------------------------------
// registered path: input register, then result register
// throughput: one tick item per cycle while the result channel is not stalled
// reset: asynchronous active low; sequencer idle, pin released, flags and read
//   byte zero, cycles_per_microsecond back to 1, both pipeline registers empty
module one_wire_bus_master_unit
  import owbm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write channel: cycles per microsecond
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  // tick input channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] data_byte_i,
  input  logic       line_level_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] line_mode_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic       no_presence_o,
  output logic [7:0] read_data_o,
  output logic       rejected_o
);

  logic [7:0] cpm_q;
  in_item_t   item_in, item_held;
  logic       item_valid;
  logic       take;
  result_t    res;

  // prescaler setting; a zero value is treated as one inside the sequencer
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpm_q <= CPM_RESET;
    end else if (cfg_valid_i) begin
      cpm_q <= cfg_data_i;
    end
  end

  // pack the input fields into one item
  assign item_in.opcode     = opcode_e'(opcode_i);
  assign item_in.data_byte  = data_byte_i;
  assign item_in.line_level = line_level_i;

  // input register: takes a new transfer when empty or whenever the held item moves on
  owbm_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (item_in),
    .item_valid_o (item_valid),
    .take_i       (take),
    .item_o       (item_held)
  );

  // sequencer: each held item is one bus tick; state and result register
  // update together, so a stalled output also stalls bus time
  owbm_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cpm_i        (cpm_q),
    .item_valid_i (item_valid),
    .item_i       (item_held),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  // result fields
  assign line_mode_o   = res.line_mode;
  assign busy_res_o    = res.busy_res;
  assign done_res_o    = res.done_res;
  assign no_presence_o = res.no_presence;
  assign read_data_o   = res.read_data;
  assign rejected_o    = res.rejected;

endmodule

// ===== rtl/owbm_in_stage.sv =====
// ----------------------------------------------------------------------------
// owbm_in_stage
// input register holding one tick item until the sequencer takes it
// ----------------------------------------------------------------------------
module owbm_in_stage
  import owbm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t item_i,
  output logic     item_valid_o,
  input  logic     take_i,
  output in_item_t item_o
);

  logic     valid_q;
  in_item_t item_q;

  // refill in the same cycle the held item moves on
  assign in_ready_o   = !valid_q || take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== rtl/owbm_seq.sv =====
// ----------------------------------------------------------------------------
// owbm_seq
// bus sequencer: one tick of state update per item, result register
// ----------------------------------------------------------------------------
module owbm_seq
  import owbm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] cpm_i,
  input  logic       item_valid_i,
  input  in_item_t   item_i,
  output logic       take_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output result_t    res_o
);

  typedef enum logic [10:0] {
    PH_IDLE       = 11'b000_0000_0001,
    PH_RST_LOW    = 11'b000_0000_0010,
    PH_RST_HIGH   = 11'b000_0000_0100,
    PH_RST_SAMPLE = 11'b000_0000_1000,
    PH_W_LOW      = 11'b000_0001_0000,
    PH_W_HIGH     = 11'b000_0010_0000,
    PH_W_REC      = 11'b000_0100_0000,
    PH_R_LOW      = 11'b000_1000_0000,
    PH_R_HIGH     = 11'b001_0000_0000,
    PH_R_WAIT     = 11'b010_0000_0000,
    PH_R_REC      = 11'b100_0000_0000
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [8:0] tl_q, tl_d;
  logic [7:0] pc_q, pc_d;
  logic [2:0] bi_q, bi_d;
  logic [7:0] sb_q, sb_d;
  logic [7:0] rb_q, rb_d;
  logic       pres_q, pres_d;
  logic [1:0] pin_q, pin_d;
  logic       out_valid_q;
  result_t    res_q, res_d;

  logic [7:0] cpm;
  logic       us_end;
  logic       busy, done, rej;

  assign cpm    = (cpm_i == 8'd0) ? 8'd1 : cpm_i;
  assign take_o = item_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    phase_d = phase_q;
    tl_d    = tl_q;
    pc_d    = pc_q;
    bi_d    = bi_q;
    sb_d    = sb_q;
    rb_d    = rb_q;
    pres_d  = pres_q;
    pin_d   = pin_q;
    busy    = 1'b0;
    done    = 1'b0;
    rej     = 1'b0;
    us_end  = 1'b0;

    // command start
    if (phase_q == PH_IDLE) begin
      case (item_i.opcode)
        OP_RESET: begin
          phase_d = PH_RST_LOW;
          tl_d    = T_RST_LOW;
          pc_d    = 8'd0;
          pin_d   = MODE_LOW;
        end
        OP_WRITE: begin
          sb_d    = item_i.data_byte;
          bi_d    = 3'd0;
          phase_d = PH_W_LOW;
          tl_d    = item_i.data_byte[0] ? T_W1_LOW : T_W0_LOW;
          pc_d    = 8'd0;
          pin_d   = MODE_LOW;
        end
        OP_READ: begin
          sb_d    = 8'd0;
          bi_d    = 3'd0;
          phase_d = PH_R_LOW;
          tl_d    = T_R_SHORT;
          pc_d    = 8'd0;
          pin_d   = MODE_LOW;
        end
        default: begin
        end
      endcase
    end else if (item_i.opcode != OP_TICK) begin
      rej = 1'b1;
    end

    res_d.line_mode = pin_d;

    if (phase_d != PH_IDLE) begin
      busy = 1'b1;
      if (phase_d == PH_RST_SAMPLE) begin
        pres_d  = item_i.line_level;
        pin_d   = item_i.line_level ? MODE_HIGH : MODE_REL;
        phase_d = PH_IDLE;
        done    = 1'b1;
      end else begin
        // sample on the first tick of the released wait
        if (phase_d == PH_R_WAIT && tl_d == T_R_WAIT && pc_d == 8'd0) begin
          sb_d[bi_d] = sb_d[bi_d] | item_i.line_level;
        end
        us_end = ({1'b0, pc_d} + 9'd1) >= {1'b0, cpm};
        if (us_end) begin
          pc_d = 8'd0;
          if (tl_d != 9'd0) begin
            tl_d = tl_d - 9'd1;
          end
          if (tl_d == 9'd0) begin
            case (phase_d)
              PH_RST_LOW: begin
                phase_d = PH_RST_HIGH; tl_d = T_RST_HIGH; pin_d = MODE_HIGH;
              end
              PH_RST_HIGH: begin
                phase_d = PH_RST_SAMPLE; tl_d = 9'd0; pin_d = MODE_REL;
              end
              PH_W_LOW: begin
                if (sb_d[0]) begin
                  phase_d = PH_W_HIGH; tl_d = T_W1_HIGH;
                end else begin
                  phase_d = PH_W_REC; tl_d = T_REC;
                end
                pin_d = MODE_HIGH;
              end
              PH_W_HIGH: begin
                phase_d = PH_W_REC; tl_d = T_REC; pin_d = MODE_HIGH;
              end
              PH_W_REC: begin
                sb_d = {1'b0, sb_d[7:1]};
                if (bi_d == 3'd7) begin
                  bi_d    = 3'd0;
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end else begin
                  bi_d    = bi_d + 3'd1;
                  phase_d = PH_W_LOW;
                  tl_d    = sb_d[0] ? T_W1_LOW : T_W0_LOW;
                  pin_d   = MODE_LOW;
                end
              end
              PH_R_LOW: begin
                phase_d = PH_R_HIGH; tl_d = T_R_SHORT; pin_d = MODE_HIGH;
              end
              PH_R_HIGH: begin
                phase_d = PH_R_WAIT; tl_d = T_R_WAIT; pin_d = MODE_REL;
              end
              PH_R_WAIT: begin
                phase_d = PH_R_REC; tl_d = T_REC; pin_d = MODE_HIGH;
              end
              PH_R_REC: begin
                if (bi_d == 3'd7) begin
                  bi_d    = 3'd0;
                  rb_d    = sb_d;
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end else begin
                  bi_d    = bi_d + 3'd1;
                  phase_d = PH_R_LOW;
                  tl_d    = T_R_SHORT;
                  pin_d   = MODE_LOW;
                end
              end
              default: begin
                phase_d = PH_IDLE;
                done    = 1'b1;
              end
            endcase
          end
        end else begin
          pc_d = pc_d + 8'd1;
        end
      end
    end

    res_d.busy_res    = busy;
    res_d.done_res    = done;
    res_d.no_presence = pres_d;
    res_d.read_data   = rb_d;
    res_d.rejected    = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tl_q        <= 9'd0;
      pc_q        <= 8'd0;
      bi_q        <= 3'd0;
      sb_q        <= 8'd0;
      rb_q        <= 8'd0;
      pres_q      <= 1'b0;
      pin_q       <= MODE_REL;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        phase_q <= phase_d;
        tl_q    <= tl_d;
        pc_q    <= pc_d;
        bi_q    <= bi_d;
        sb_q    <= sb_d;
        rb_q    <= rb_d;
        pres_q  <= pres_d;
        pin_q   <= pin_d;
      end
      if (take_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // a finishing tick always belongs to a sequence
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.done_res |-> res_q.busy_res)
    else $error("done without busy");

  // a command is only refused inside a sequence
  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.rejected |-> res_q.busy_res)
    else $error("rejected while idle");

  // a busy tick that does not finish leaves the sequencer active
  a_busy_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && busy && !done |=> phase_q != PH_IDLE)
    else $error("sequence dropped");

  // pin drive code is one of the three legal codes
  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> res_q.line_mode != 2'd3)
    else $error("illegal pin drive");

endmodule

// ===== verif/owbm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// owbm_checker
// follows the config, tick and result channels of the one-wire bus master,
// steps its own copy of the bus sequencer once per tick transfer and compares
// every result transfer, field by field, with the oldest outstanding tick
// ----------------------------------------------------------------------------
module owbm_checker
  import owbm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [1:0] opcode_i,
  input  logic [7:0] data_byte_i,
  input  logic       line_level_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [1:0] line_mode_i,
  input  logic       busy_res_i,
  input  logic       done_res_i,
  input  logic       no_presence_i,
  input  logic [7:0] read_data_i,
  input  logic       rejected_i,
  output int         mismatch_count_o,
  output int         results_pending_o
);

  typedef enum logic [3:0] {
    SQ_IDLE       = 4'd0,
    SQ_RST_LOW    = 4'd1,
    SQ_RST_HIGH   = 4'd2,
    SQ_RST_SAMPLE = 4'd3,
    SQ_WR_LOW     = 4'd4,
    SQ_WR_HIGH    = 4'd5,
    SQ_WR_REC     = 4'd6,
    SQ_RD_LOW     = 4'd7,
    SQ_RD_HIGH    = 4'd8,
    SQ_RD_WAIT    = 4'd9,
    SQ_RD_REC     = 4'd10
  } seq_phase_e;

  seq_phase_e phase;
  logic [8:0] us_left;
  logic [7:0] sub_tick;
  logic [2:0] bit_pos;
  logic [7:0] data_shift;
  logic [7:0] last_read;
  logic       presence_line;
  logic [1:0] pin_drive;
  logic [7:0] cpm_reg;
  result_t    tick_results_q[$];

  function automatic logic [1:0] drive_of(seq_phase_e ph);
    case (ph)
      SQ_RST_LOW, SQ_WR_LOW, SQ_RD_LOW: return MODE_LOW;
      SQ_RST_HIGH, SQ_WR_HIGH, SQ_WR_REC, SQ_RD_HIGH, SQ_RD_REC: return MODE_HIGH;
      default: return MODE_REL;
    endcase
  endfunction

  function automatic void open_span(seq_phase_e ph, logic [8:0] us);
    phase     = ph;
    us_left   = us;
    sub_tick  = '0;
    pin_drive = drive_of(ph);
  endfunction

  // end of a timed span, returns 1 when the whole sequence is over
  function automatic logic close_span();
    case (phase)
      SQ_RST_LOW:  open_span(SQ_RST_HIGH, T_RST_HIGH);
      SQ_RST_HIGH: open_span(SQ_RST_SAMPLE, 9'd0);
      SQ_WR_LOW: begin
        if (data_shift[0]) open_span(SQ_WR_HIGH, T_W1_HIGH);
        else open_span(SQ_WR_REC, T_REC);
      end
      SQ_WR_HIGH:  open_span(SQ_WR_REC, T_REC);
      SQ_WR_REC: begin
        data_shift = data_shift >> 1;
        if (bit_pos == 3'd7) begin
          bit_pos = '0;
          phase   = SQ_IDLE;
          return 1'b1;
        end
        bit_pos = bit_pos + 1'b1;
        open_span(SQ_WR_LOW, data_shift[0] ? T_W1_LOW : T_W0_LOW);
      end
      SQ_RD_LOW:   open_span(SQ_RD_HIGH, T_R_SHORT);
      SQ_RD_HIGH:  open_span(SQ_RD_WAIT, T_R_WAIT);
      SQ_RD_WAIT:  open_span(SQ_RD_REC, T_REC);
      SQ_RD_REC: begin
        if (bit_pos == 3'd7) begin
          bit_pos   = '0;
          last_read = data_shift;
          phase     = SQ_IDLE;
          return 1'b1;
        end
        bit_pos = bit_pos + 1'b1;
        open_span(SQ_RD_LOW, T_R_SHORT);
      end
      default: begin
        phase = SQ_IDLE;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // one tick transfer through the sequencer
  function automatic result_t sequencer_tick(opcode_e op, logic [7:0] data, logic line);
    result_t r;
    int      ticks_per_us;
    r = '0;
    ticks_per_us = (cpm_reg == 8'd0) ? 1 : int'(cpm_reg);
    if (phase == SQ_IDLE) begin
      case (op)
        OP_RESET: open_span(SQ_RST_LOW, T_RST_LOW);
        OP_WRITE: begin
          data_shift = data;
          bit_pos    = '0;
          open_span(SQ_WR_LOW, data[0] ? T_W1_LOW : T_W0_LOW);
        end
        OP_READ: begin
          data_shift = '0;
          bit_pos    = '0;
          open_span(SQ_RD_LOW, T_R_SHORT);
        end
        default: ;
      endcase
    end else if (op != OP_TICK) begin
      r.rejected = 1'b1;
    end
    r.line_mode = pin_drive;
    if (phase != SQ_IDLE) begin
      r.busy_res = 1'b1;
      if (phase == SQ_RST_SAMPLE) begin
        presence_line = line;
        pin_drive     = line ? MODE_HIGH : MODE_REL;
        phase         = SQ_IDLE;
        r.done_res    = 1'b1;
      end else begin
        // the line is sampled on the first tick of the released wait
        if (phase == SQ_RD_WAIT && us_left == T_R_WAIT && sub_tick == 8'd0)
          data_shift[bit_pos] = data_shift[bit_pos] | line;
        if ((int'(sub_tick) + 1) >= ticks_per_us) begin
          sub_tick = '0;
          if (us_left != 9'd0) us_left = us_left - 1'b1;
          if (us_left == 9'd0) r.done_res = close_span();
        end else begin
          sub_tick = sub_tick + 1'b1;
        end
      end
    end
    r.no_presence = presence_line;
    r.read_data   = last_read;
    return r;
  endfunction

  task automatic match_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      phase         = SQ_IDLE;
      us_left       = '0;
      sub_tick      = '0;
      bit_pos       = '0;
      data_shift    = '0;
      last_read     = '0;
      presence_line = 1'b0;
      pin_drive     = MODE_REL;
      cpm_reg       = CPM_RESET;
      tick_results_q.delete();
      mismatch_count_o  = 0;
      results_pending_o = 0;
    end else begin
      // results first, so a result never meets a tick of this same edge
      if (out_valid_i && out_ready_i) begin
        if (tick_results_q.size() == 0) begin
          $display("%0t: result with no tick outstanding, expected none, got mode %0d busy %0b",
                   $time, line_mode_i, busy_res_i);
          mismatch_count_o++;
        end else begin
          want = tick_results_q.pop_front();
          match_field("line_mode", 8'(want.line_mode), 8'(line_mode_i));
          match_field("busy_res", 8'(want.busy_res), 8'(busy_res_i));
          match_field("done_res", 8'(want.done_res), 8'(done_res_i));
          match_field("no_presence", 8'(want.no_presence), 8'(no_presence_i));
          match_field("read_data", want.read_data, read_data_i);
          match_field("rejected", 8'(want.rejected), 8'(rejected_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) cpm_reg = cfg_data_i;
      if (in_valid_i && in_ready_i)
        tick_results_q.push_back(sequencer_tick(opcode_e'(opcode_i), data_byte_i,
                                                line_level_i));
      results_pending_o = tick_results_q.size();
    end
  end

endmodule

// ===== verif/tb_one_wire_bus_master_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master_unit
// drives bus ticks and prescaler writes into the one-wire bus master with
// random gaps and result stalls; a checker beside the block steps its own
// sequencer per tick and compares each result, this top gives the verdict
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master_unit;
  import owbm_pkg::*;

  // random tick transfers after the directed part
  localparam int RANDOM_TICKS = 1450;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       cfg_valid_i  = 1'b0;
  logic [7:0] cfg_data_i   = 8'h00;
  logic       in_valid_i   = 1'b0;
  logic [1:0] opcode_i     = OP_TICK;
  logic [7:0] data_byte_i  = 8'h00;
  logic       line_level_i = 1'b1;
  logic       out_ready_i  = 1'b0;

  logic       cfg_ready_o;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] line_mode_o;
  logic       busy_res_o;
  logic       done_res_o;
  logic       no_presence_o;
  logic [7:0] read_data_o;
  logic       rejected_o;

  int         mismatch_count;
  int         results_pending;
  // prescaler value last written, so a slow setting is not kept for long
  logic [7:0] cpm_now = CPM_RESET;

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  one_wire_bus_master_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .data_byte_i  (data_byte_i),
    .line_level_i (line_level_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .line_mode_o  (line_mode_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .no_presence_o(no_presence_o),
    .read_data_o  (read_data_o),
    .rejected_o   (rejected_o)
  );

  owbm_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .opcode_i         (opcode_i),
    .data_byte_i      (data_byte_i),
    .line_level_i     (line_level_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .line_mode_i      (line_mode_o),
    .busy_res_i       (busy_res_o),
    .done_res_i       (done_res_o),
    .no_presence_i    (no_presence_o),
    .read_data_i      (read_data_o),
    .rejected_i       (rejected_o),
    .mismatch_count_o (mismatch_count),
    .results_pending_o(results_pending)
  );

  // idle cycles before a tick: mostly none or short, now and then long
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one tick transfer; called right after a rising edge or a falling edge,
  // returns right after the rising edge that took the tick
  task automatic send_tick(opcode_e op, logic [7:0] data, logic line, bit quiet);
    int gap;
    gap = pick_gap(quiet);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    data_byte_i  <= data;
    line_level_i <= line;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // prescaler write, only once every tick in flight has produced its result;
  // the sequencer itself may still be mid-span, which is the point of lowering
  // the prescaler between ticks
  task automatic set_cpm(logic [7:0] value);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (results_pending != 0) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cpm_now = value;
  endtask

  // result side: bursts of ready with stalls in between, some bursts long
  initial begin
    int run;
    int stall;
    int r;
    wait (rst_ni);
    forever begin
      run = $urandom_range(1, 60);
      r   = $urandom_range(0, 9);
      stall = (r < 3) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(8, 30);
      repeat (run) begin
        @(negedge clk_i);
        out_ready_i <= 1'b1;
      end
      repeat (stall) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
      end
    end
  end

  // stimulus and verdict
  initial begin
    int         sent;
    int         chunk_len;
    int         n;
    bit         hammer;
    bit         quiet;
    opcode_e    next_cmd;
    opcode_e    op;
    logic [7:0] cmd_data;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // slowest prescaler, start a read and hit it with every command while busy
    set_cpm(8'd255);
    send_tick(OP_READ, 8'hFF, 1'b1, 1'b0);
    send_tick(OP_WRITE, 8'h00, 1'b0, 1'b0);
    send_tick(OP_RESET, 8'hFF, 1'b1, 1'b0);
    send_tick(OP_READ, 8'h00, 1'b0, 1'b0);
    for (n = 0; n < 6; n++)
      send_tick(OP_TICK, n[0] ? 8'hFF : 8'h00, n[0], 1'b0);
    // prescaler dropped to zero mid-microsecond: zero counts as one and the
    // partly counted microsecond closes on the next tick
    set_cpm(8'd0);
    send_tick(OP_WRITE, 8'hFF, 1'b0, 1'b0);
    for (n = 0; n < 3; n++)
      send_tick(OP_TICK, 8'hA5, n[0], 1'b0);

    // random part in chunks: each chunk picks one next command and either
    // sends it on every tick (so it also lands on the last busy tick and
    // starts right after) or sends random commands now and then among plain ticks
    sent = 0;
    while (sent < RANDOM_TICKS) begin
      if (cpm_now > 8'd2) begin
        set_cpm(8'd1);
      end else if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 9))
          0:       set_cpm(8'd0);
          1:       set_cpm(8'd2);
          2:       set_cpm(8'd255);
          default: set_cpm(8'd1);
        endcase
      end
      next_cmd = opcode_e'($urandom_range(1, 3));
      case ($urandom_range(0, 3))
        0:       cmd_data = 8'h00;
        1:       cmd_data = 8'hFF;
        default: cmd_data = 8'($urandom);
      endcase
      hammer    = ($urandom_range(0, 2) == 0);
      quiet     = ($urandom_range(0, 3) == 0);
      chunk_len = (cpm_now == 8'd255) ? $urandom_range(20, 80) : $urandom_range(80, 300);
      for (n = 0; n < chunk_len && sent < RANDOM_TICKS; n++) begin
        if (hammer) op = next_cmd;
        else if ($urandom_range(0, 19) == 0) op = opcode_e'($urandom_range(1, 3));
        else op = OP_TICK;
        send_tick(op, (op == OP_TICK) ? 8'($urandom) : cmd_data, 1'($urandom), quiet);
        sent++;
      end
    end

    // drain, then wait for anything stray from the two-stage pipeline
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    for (n = 0; n < 5000 && results_pending != 0; n++) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (results_pending != 0)
      $display("%0t: %0d tick results never arrived", $time, results_pending);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
